FILE: sv/vlbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vlbe_pkg;

  localparam int GroupBits  = 7;
  localparam int NumGroups  = 10;
  localparam int WordBits   = 64;
  localparam int QueueDepth = 2;

  localparam logic [6:0] GroupMask = 7'h7f;

  // one classified value waiting for the byte emitter
  typedef struct packed {
    logic [63:0] value;
    logic        neg;
    logic [3:0]  nbytes;
  } entry_t;

endpackage
`default_nettype wire

FILE: sv/vlbe_front.sv
`timescale 1ns / 1ps
`default_nettype none
module vlbe_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             kind,
  input  wire logic [63:0]      value,
  output logic                  push,
  output vlbe_pkg::entry_t      push_entry,
  input  wire logic             full
);

  logic        hold_valid;
  logic        hold_kind;
  logic [63:0] hold_value;
  logic        accept;
  logic        neg;
  logic [63:0] mag;
  logic [64:0] w;
  logic [vlbe_pkg::NumGroups-1:1] nz;
  logic [3:0]  nb;

  assign busy   = hold_valid & full;
  assign accept = start & ~busy;
  assign push   = hold_valid & ~full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_kind  <= kind;
      hold_value <= value;
    end
  end

  // bit count = bit length of w: signed adds a sign bit, unsigned counts zero as one bit
  always_comb begin
    neg = hold_kind & hold_value[63];
    mag = neg ? ~hold_value : hold_value;
    w   = hold_kind ? {mag, 1'b1} : {1'b0, hold_value | 64'd1};
    for (int g = 1; g < vlbe_pkg::NumGroups - 1; g++) begin
      nz[g] = |w[g*vlbe_pkg::GroupBits +: vlbe_pkg::GroupBits];
    end
    nz[vlbe_pkg::NumGroups-1] = |w[64:63];
    nb = 4'd1;
    for (int g = 1; g < vlbe_pkg::NumGroups; g++) begin
      if (nz[g]) begin
        nb = 4'(g + 1);
      end
    end
    push_entry.value  = hold_value;
    push_entry.neg    = neg;
    push_entry.nbytes = nb;
  end

endmodule
`default_nettype wire

FILE: sv/vlbe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module vlbe_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire vlbe_pkg::entry_t  push_entry,
  output logic                   full,
  input  wire logic              pop,
  output vlbe_pkg::entry_t       head,
  output logic                   empty
);

  localparam int PtrBits = $clog2(vlbe_pkg::QueueDepth);
  localparam int CntBits = $clog2(vlbe_pkg::QueueDepth + 1);

  vlbe_pkg::entry_t   slots [vlbe_pkg::QueueDepth];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [CntBits-1:0] count;

  assign full  = (count == CntBits'(vlbe_pkg::QueueDepth));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrBits'(vlbe_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(vlbe_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

FILE: sv/vlbe_back.sv
`timescale 1ns / 1ps
`default_nettype none
module vlbe_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire vlbe_pkg::entry_t head,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  byte_valid,
  output logic [7:0]            code_byte,
  output logic                  last
);

  localparam int ExtBits = vlbe_pkg::NumGroups * vlbe_pkg::GroupBits;

  logic               active;
  logic [3:0]         idx;
  logic [63:0]        cur_value;
  logic               cur_neg;
  logic [ExtBits-1:0] ext;
  logic [6:0]         group;
  logic               final_byte;

  assign final_byte = (idx == 4'd0);
  assign pop        = ~empty & (~active | final_byte);

  // groups above bit 63 take copies of the sign for negative signed values
  always_comb begin
    ext   = {{(ExtBits - vlbe_pkg::WordBits){cur_neg}}, cur_value};
    group = '0;
    for (int g = 0; g < vlbe_pkg::NumGroups; g++) begin
      if (idx == 4'(g)) begin
        group = ext[g*vlbe_pkg::GroupBits +: vlbe_pkg::GroupBits] & vlbe_pkg::GroupMask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      byte_valid <= 1'b0;
    end else begin
      byte_valid <= active;
      if (pop) begin
        active <= 1'b1;
      end else if (active && final_byte) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_byte <= {~final_byte, group};
    last      <= final_byte;
    if (pop) begin
      cur_value <= head.value;
      cur_neg   <= head.neg;
      idx       <= head.nbytes - 4'd1;
    end else if (active && !final_byte) begin
      idx <= idx - 4'd1;
    end
  end

endmodule
`default_nettype wire

FILE: sv/varint_big_endian_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// variable-length big-endian integer encoder
// request: kind and value, taken at a clock edge where start is high and busy is low
// kind 0 encodes value unsigned, kind 1 encodes it as two's complement with a sign bit
// results: 1 to 10 bytes, most significant 7-bit group first, one per cycle while
// byte_valid is high; bit 7 of code_byte is set on all but the final byte,
// and last marks the final byte
// a request passes the front hold register, a queue slot and the emitter state
// before its first byte reaches the output register; the back-stage emitter sends
// one byte per cycle while it holds a value and pops the next one on its last byte
// the front stage classifies the next value while the back stage still emits,
// and a two-entry queue between them keeps requests flowing back to back
// busy rises only when the queue is full and the front holds a classified value
// the receiver cannot stall: each byte is on the ports for exactly one cycle
// reset (synchronous, rst high) empties the front, the queue and the emitter;
// a request in flight is dropped
module varint_big_endian_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind,
  input  wire logic [63:0] value,
  output logic             byte_valid,
  output logic [7:0]       code_byte,
  output logic             last
);

  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  vlbe_pkg::entry_t push_entry;
  vlbe_pkg::entry_t head;

  vlbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .value      (value),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  vlbe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  vlbe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .byte_valid (byte_valid),
    .code_byte  (code_byte),
    .last       (last)
  );

endmodule
`default_nettype wire
